// ----- rtl/ladb_pkg.sv -----
// Shared types and constants for the resistor-ladder button debouncer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ladb_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int BTN_W    = 4;

  // ladder register file is fixed at five entries, indexed by three bits
  localparam int LADDER_REGS  = 5;
  localparam int LADDER_IDX_W = 3;

  // repeat dividend: duration - hold + half period, below 2^33 when non-negative
  localparam int DIV_W = TIME_W + 1;

  localparam int NUM_BUTTONS_DEF    = 5;
  localparam int ADC_FULL_SCALE_DEF = 1024;

  typedef logic signed [BTN_W-1:0] btn_t;

  localparam btn_t BTN_NONE = -4'sd1;

  typedef enum logic [2:0] {
    REG_LADDER_0 = 3'd0,
    REG_LADDER_1 = 3'd1,
    REG_LADDER_2 = 3'd2,
    REG_LADDER_3 = 3'd3,
    REG_LADDER_4 = 3'd4,
    REG_DEBOUNCE = 3'd5,
    REG_HOLD     = 3'd6,
    REG_REPEAT   = 3'd7
  } cfg_reg_t;

  localparam logic [SAMPLE_W-1:0] LADDER_RESET [LADDER_REGS] =
    '{10'd0, 10'd145, 10'd329, 10'd505, 10'd741};

  localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [MS_W-1:0] HOLD_RESET     = 16'd500;
  localparam logic [MS_W-1:0] REPEAT_RESET   = 16'd100;

endpackage

// ----- rtl/ladb_div.sv -----
// Bit-serial restoring divider giving the remainder of an unsigned dividend.
// Depends on ladb_pkg for widths; one quotient bit per cycle.
`timescale 1ns / 1ps

module ladb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ladb_pkg::DIV_W-1:0]  dividend,
  input  logic [ladb_pkg::MS_W-1:0]   divisor,
  output logic                        done,
  output logic [ladb_pkg::MS_W-1:0]   remainder
);
  import ladb_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] shreg;
  logic [MS_W-1:0]  dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [MS_W:0]    trial;
  logic [MS_W:0]    diff;

  assign trial = {remainder, shreg[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CntW'(DIV_W - 1));
      if (start) begin
        busy      <= 1'b1;
        shreg     <= dividend;
        dvs       <= divisor;
        remainder <= '0;
        cnt       <= '0;
      end else if (busy) begin
        shreg <= {shreg[DIV_W-2:0], 1'b0};
        if (!diff[MS_W]) begin
          remainder <= diff[MS_W-1:0];
        end else begin
          remainder <= trial[MS_W-1:0];
        end
        if (cnt == CntW'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/analog_ladder_button_debouncer.sv -----
// Resistor-ladder button debouncer: classification, debounce, hold and repeat.
// Depends on ladb_pkg and ladb_div (serial remainder for the repeat phase).
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid/in_ready): one ADC sample with its millisecond
//   timestamp per transaction. Output channel (out_valid/out_ready): one
//   result per sample, in order. Config channel (cfg_valid/cfg_ready) writes
//   ladder values, debounce, hold and repeat times; always ready. The user must see
//   that it is only written while the block is idle; the block does not enforce it.
//   Timing: the sample is classified by walking the ladder one boundary per
//   cycle, then come the debounce and hold checks; with a button held, the
//   repeat phase then needs the remainder of a 33-bit value by repeat_ms
//   from the serial divider, one bit per cycle. in_ready is low from the
//   input transaction until the result is registered, so no new sample is
//   taken before the block is through with the last one.
//   The result sits in an output register, so a new sample is taken while it
//   waits; if the receiver stalls, the next result waits in the sequencer and
//   no further sample is taken until the register frees.
//   Reset: all registers return to their listed reset values, no button held,
//   all time state zero, output empty.
//
module analog_ladder_button_debouncer #(
  parameter int NUM_BUTTONS    = ladb_pkg::NUM_BUTTONS_DEF,
  parameter int ADC_FULL_SCALE = ladb_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [ladb_pkg::MS_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ladb_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ladb_pkg::TIME_W-1:0]    now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ladb_pkg::btn_t                 held_button,
  output ladb_pkg::btn_t                 press_event_button,
  output ladb_pkg::btn_t                 release_event_button,
  output logic [ladb_pkg::TIME_W-1:0]    press_duration,
  output logic                           hold_reached,
  output logic                           hold_event,
  output logic                           repeat_event,
  output logic                           release_was_long
);
  import ladb_pkg::*;

  localparam int IdxW = $clog2(NUM_BUTTONS + 1);
  localparam int SumW = $clog2(ADC_FULL_SCALE + 1) + 1;
  localparam int ExtW = TIME_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLASS, ST_DEBOUNCE, ST_PREP, ST_DIV, ST_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [SAMPLE_W-1:0] ladder [LADDER_REGS];
  logic [MS_W-1:0]     debounce_ms;
  logic [MS_W-1:0]     hold_ms;
  logic [MS_W-1:0]     repeat_ms;

  // per-sample working registers
  logic [SAMPLE_W-1:0] sample_r;
  logic [IdxW-1:0]     idx;
  logic [SAMPLE_W-1:0] lad_prev;
  btn_t                c_btn;
  btn_t                press_ev;
  btn_t                rel_ev;
  logic [TIME_W-1:0]   dur;
  logic                reached;
  logic                hold_ev;
  logic                long_rel;
  logic                t_neg;

  // persistent state
  btn_t                stable;
  btn_t                cand_btn;
  logic [TIME_W-1:0]   cand_since;
  logic [TIME_W-1:0]   press_start;
  logic [TIME_W-1:0]   rel_ps;
  logic [TIME_W-1:0]   prev_time;
  logic [TIME_W-1:0]   cur_time;

  // ladder walk: boundary between the previous entry and the one read now
  logic [LADDER_IDX_W-1:0] rd_idx;
  logic [SumW-1:0]         cur_v;
  logic [SumW-1:0]         bsum;
  logic                    below;

  assign rd_idx = (idx < IdxW'(NUM_BUTTONS)) ? LADDER_IDX_W'(idx) : '0;
  assign cur_v  = (idx == IdxW'(NUM_BUTTONS)) ? SumW'(ADC_FULL_SCALE)
                                              : SumW'(ladder[rd_idx]);
  assign bsum   = SumW'(lad_prev) + cur_v;
  assign below  = SumW'(sample_r) < {1'b0, bsum[SumW-1:1]};

  // debounce
  logic [TIME_W-1:0] cand_since_next;
  logic              accept_btn;

  assign cand_since_next = (c_btn != cand_btn) ? cur_time : cand_since;
  assign accept_btn = ((cur_time - cand_since_next) > TIME_W'(debounce_ms))
                      && (c_btn != stable);

  // hold and repeat arithmetic
  logic [MS_W-1:0]   period;
  logic [TIME_W-1:0] dur_next;
  logic [TIME_W-1:0] step;
  logic [ExtW-1:0]   t_val;
  logic [ExtW-1:0]   hold_off;
  logic [ExtW-1:0]   rep_off;
  logic [ExtW-1:0]   hold_diff;
  logic [ExtW-1:0]   rep_diff;
  logic              hold_cross;
  logic              rep_cross;
  logic              div_done;
  logic [MS_W-1:0]   div_rem;

  assign period   = (repeat_ms == '0) ? MS_W'(1) : repeat_ms;
  assign dur_next = cur_time - press_start;
  assign step     = cur_time - prev_time;
  assign t_val    = ExtW'(dur_next) - ExtW'(hold_ms) + ExtW'(period[MS_W-1:1]);

  assign hold_off   = ExtW'(hold_ms);
  assign hold_diff  = ExtW'(dur_next) - hold_off;
  assign hold_cross = (ExtW'(dur_next) >= hold_off) && (hold_diff < ExtW'(step));

  // hold + period * floor(t / period) is dur + half - (t mod period)
  assign rep_off   = t_neg ? ExtW'(hold_ms)
                           : ExtW'(dur) + ExtW'(period[MS_W-1:1]) - ExtW'(div_rem);
  assign rep_diff  = ExtW'(dur) - rep_off;
  assign rep_cross = (ExtW'(dur) >= rep_off) && (rep_diff < ExtW'(step));

  ladb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_PREP && stable != BTN_NONE),
    .dividend  (t_val[DIV_W-1:0]),
    .divisor   (period),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      ladder      <= LADDER_RESET;
      debounce_ms <= DEBOUNCE_RESET;
      hold_ms     <= HOLD_RESET;
      repeat_ms   <= REPEAT_RESET;
      stable      <= BTN_NONE;
      cand_btn    <= BTN_NONE;
      cand_since  <= '0;
      press_start <= '0;
      rel_ps      <= '0;
      prev_time   <= '0;
      cur_time    <= '0;
      idx         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index) inside
          REG_LADDER_0, REG_LADDER_1, REG_LADDER_2, REG_LADDER_3, REG_LADDER_4: begin
            ladder[cfg_index] <= cfg_data[SAMPLE_W-1:0];
          end
          REG_DEBOUNCE: debounce_ms <= cfg_data;
          REG_HOLD:     hold_ms     <= cfg_data;
          REG_REPEAT:   repeat_ms   <= cfg_data;
          default: ;
        endcase
      end

      // the finish state reloads the register itself
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sample_r  <= sample;
            prev_time <= cur_time;
            cur_time  <= now_ms;
            idx       <= '0;
            state     <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (idx == '0) begin
            lad_prev <= ladder[rd_idx];
            idx      <= idx + 1'b1;
          end else if (below) begin
            c_btn <= btn_t'(idx) - btn_t'(1);
            state <= ST_DEBOUNCE;
          end else if (idx == IdxW'(NUM_BUTTONS)) begin
            c_btn <= BTN_NONE;
            state <= ST_DEBOUNCE;
          end else begin
            lad_prev <= ladder[rd_idx];
            idx      <= idx + 1'b1;
          end
        end
        ST_DEBOUNCE: begin
          cand_since <= cand_since_next;
          cand_btn   <= c_btn;
          press_ev   <= accept_btn ? c_btn : BTN_NONE;
          rel_ev     <= accept_btn ? stable : BTN_NONE;
          if (accept_btn) begin
            rel_ps   <= press_start;
            stable   <= c_btn;
            if (c_btn != BTN_NONE) begin
              press_start <= cur_time;
            end
          end
          state <= ST_PREP;
        end
        ST_PREP: begin
          long_rel <= (rel_ev != BTN_NONE) &&
                      ((cur_time - rel_ps) >= TIME_W'(hold_ms));
          t_neg    <= t_val[ExtW-1];
          if (stable != BTN_NONE) begin
            dur     <= dur_next;
            reached <= dur_next >= TIME_W'(hold_ms);
            hold_ev <= hold_cross;
            state   <= ST_DIV;
          end else begin
            dur     <= '0;
            reached <= 1'b0;
            hold_ev <= 1'b0;
            state   <= ST_FINISH;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            held_button          <= stable;
            press_event_button   <= press_ev;
            release_event_button <= rel_ev;
            press_duration       <= dur;
            hold_reached         <= reached;
            hold_event           <= hold_ev;
            repeat_event         <= (stable != BTN_NONE) && rep_cross;
            release_was_long     <= long_rel;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ladb_chk.sv -----
// Port-level checks for the ladder debouncer, bound to the top level.
// Depends on ladb_pkg; sees the top-level ports only.
`timescale 1ns / 1ps

module ladb_chk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  ladb_pkg::btn_t               held_button,
  input  ladb_pkg::btn_t               press_event_button,
  input  ladb_pkg::btn_t               release_event_button,
  input  logic [ladb_pkg::TIME_W-1:0]  press_duration,
  input  logic                         hold_reached,
  input  logic                         hold_event,
  input  logic                         repeat_event,
  input  logic                         release_was_long
);
  import ladb_pkg::*;

  // a stalled result transaction keeps its held button and press duration
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(held_button)
      && $stable(press_duration))
    else $error("result changed while stalled");

  // one sample at a time: the input closes after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened while a sample was in work");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && held_button == BTN_NONE |->
      press_duration == '0 && !hold_reached && !hold_event && !repeat_event)
    else $error("hold activity with no button held");

  a_long_needs_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_event_button == BTN_NONE |-> !release_was_long)
    else $error("long release without a release");

  a_press_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_event_button != BTN_NONE |->
      held_button == press_event_button && press_duration == '0)
    else $error("press event disagrees with held button");

endmodule

bind analog_ladder_button_debouncer ladb_chk u_ladb_chk (.*);
